FILE: hw/rtl/gnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gnp_pkg;

	localparam int UW = 24;
	localparam int SW = 32;
	localparam int UNIFORM_BITS_DEF = 24;

	// shared multiplier: A x B, B consumed one digit per cycle, MSB first
	localparam int MUL_AW    = 36;
	localparam int MUL_BW    = 40;
	localparam int MUL_DW    = 8;
	localparam int MUL_PW    = MUL_AW + MUL_BW;
	localparam int MUL_STEPS = MUL_BW / MUL_DW;

	// ratio v^2/s in Q1.32
	localparam int DIV_NW    = 49;
	localparam int DIV_DW    = 48;
	localparam int DIV_QW    = 33;
	localparam int DIV_STEPS = 32;

	// integer square root, two radicand bits per cycle
	localparam int SQ_XW = 46;
	localparam int SQ_RW = 23;

	localparam int LOG_ITERS = 28;
	localparam logic [28:0] LN2_Q29 = 29'd372130559;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOAD,
		S_SQ1,
		S_SQ2,
		S_NORM,
		S_LOG,
		S_LN,
		S_DIV,
		S_RL,
		S_SQRT,
		S_SCALE,
		S_DONE
	} gnp_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gnp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gnp_item_if import gnp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [UW-1:0]        uniform_a;
	logic [UW-1:0]        uniform_b;
	logic signed [UW-1:0] gain;
	logic signed [UW-1:0] bias;
	modport source(output valid, uniform_a, uniform_b, gain, bias, input ready);
	modport sink(input valid, uniform_a, uniform_b, gain, bias, output ready);
endinterface

interface gnp_result_if import gnp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sample;
	logic                 rejected;
	modport source(output valid, sample, rejected, input ready);
	modport sink(input valid, sample, rejected, output ready);
endinterface

interface gnp_cfg_if;
	logic valid;
	logic ready;
	logic noise_kind;
	modport source(output valid, noise_kind, input ready);
	modport sink(input valid, noise_kind, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/gnp_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module gnp_mul import gnp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MUL_AW-1:0] a,
	input  wire logic [MUL_BW-1:0] b,
	output logic                   done,
	output logic [MUL_PW-1:0]      prod
);
	localparam int CW = $clog2(MUL_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(MUL_STEPS - 1);

	logic [MUL_AW-1:0]        a_q;
	logic [MUL_BW-1:0]        b_q;
	logic [MUL_PW-1:0]        acc_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [MUL_AW+MUL_DW-1:0] part;

	assign part = a_q * b_q[MUL_BW-1 -: MUL_DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[MUL_PW-MUL_DW-1:0], {MUL_DW{1'b0}}} + MUL_PW'(part);
			b_q   <= b_q << MUL_DW;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

FILE: hw/rtl/gnp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module gnp_div import gnp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   done,
	output logic [DIV_QW-1:0]      quo
);
	localparam int CW = $clog2(DIV_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_QW-1:0] q_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              first;
	logic [DIV_NW-1:0] diff0;
	logic [DIV_DW:0]   t;
	logic              ge;
	logic [DIV_DW:0]   tdiff;

	assign first = num >= DIV_NW'(den);
	assign diff0 = num - DIV_NW'(den);
	assign t     = {rem_q, 1'b0};
	assign ge    = t >= {1'b0, den_q};
	assign tdiff = t - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= first ? diff0[DIV_DW-1:0] : num[DIV_DW-1:0];
			q_q   <= DIV_QW'(first);
		end else if (busy_q) begin
			rem_q <= ge ? tdiff[DIV_DW-1:0] : t[DIV_DW-1:0];
			q_q   <= {q_q[DIV_QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule
`default_nettype wire

FILE: hw/rtl/gnp_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module gnp_sqrt import gnp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SQ_XW-1:0] x,
	output logic                  done,
	output logic [SQ_RW-1:0]      root
);
	localparam int CW = $clog2(SQ_RW);
	localparam logic [CW-1:0] CNT_LAST = CW'(SQ_RW - 1);

	logic [SQ_XW-1:0] x_q;
	logic [SQ_RW+1:0] rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SQ_RW+3:0] rin;
	logic [SQ_RW+3:0] trial;
	logic             ge;
	logic [SQ_RW+3:0] rdiff;

	// remainder stays below 2*root+1, so it fits two bits over the root
	assign rin   = {rem_q, x_q[SQ_XW-1 -: 2]};
	assign trial = (SQ_RW+4)'({root_q, 2'b01});
	assign ge    = rin >= trial;
	assign rdiff = rin - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? rdiff[SQ_RW+1:0] : rin[SQ_RW+1:0];
			root_q <= {root_q[SQ_RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

FILE: hw/rtl/gaussian_noise_polar_core.sv
// Uniform items and gaussian items served from the cached spare need one scaling multiply.
// Rejected polar candidates stop after the two squarings; fresh polar pairs go through the
// leading-one shift, the 28 log squarings through the shared 8-bit-digit multiplier, and
// two divides and two square roots.
// One item in flight; the next is taken while the previous result waits in the output register.
// Asynchronous active-low reset: idle, gaussian mode, spare cleared, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_noise_polar_core import gnp_pkg::*; #(
	parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gnp_item_if.sink   item,
	gnp_result_if.source result,
	gnp_cfg_if.sink    cfg
);
	localparam int KEEP = (UNIFORM_BITS > UW) ? UW : UNIFORM_BITS;
	localparam logic [UW-1:0] UMASK = ~((UW'(1) << (UW - KEEP)) - UW'(1));

	function automatic logic [UW:0] umag(input logic [UW-1:0] u);
		logic [UW:0] t;
		begin
			t = {u, 1'b0};
			return u[UW-1] ? t - (UW+1)'(1 << UW) : (UW+1)'(1 << UW) - t;
		end
	endfunction

	function automatic logic [SW-1:0] round_sat(input logic signed [51:0] acc,
			input logic uni);
		logic signed [51:0] r;
		begin
			r = uni ? ((acc + 52'sd524288) >>> 20) : ((acc + 52'sd32768) >>> 16);
			if (r > 52'sd2147483647)
				return 32'h7fffffff;
			else if (r < -52'sd2147483648)
				return 32'h80000000;
			else
				return r[SW-1:0];
		end
	endfunction

	gnp_state_t state_q, state_d;

	logic                 noise_kind_q;
	logic signed [UW-1:0] spare_q;
	logic                 spare_valid_q;
	logic [UW-1:0]        ua_q;
	logic signed [UW-1:0] gain_q;
	logic signed [UW-1:0] bias_q;
	logic [UW:0]          mag1_q, mag2_q;
	logic                 neg1_q, neg2_q;
	logic [48:0]          sq1_q, sq2_q;
	logic [47:0]          s_q;
	logic [47:0]          norm_q;
	logic [5:0]           cnt_q;
	logic [LOG_ITERS-1:0] f_q;
	logic [4:0]           it_q;
	logic [31:0]          l_q;
	logic                 sel_q;
	logic [SQ_RW-1:0]     n1_q;
	logic                 pneg_q;
	logic [SW-1:0]        res_sample_q;
	logic                 res_rej_q;
	logic [SW-1:0]        out_sample_q;
	logic                 out_rej_q;
	logic                 out_valid_q;

	logic              mul_start, mul_done;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic [MUL_PW-1:0] mul_prod;
	logic              div_start, div_done;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_QW-1:0] div_quo;
	logic              sqrt_start, sqrt_done;
	logic [SQ_XW-1:0]  sqrt_x;
	logic [SQ_RW-1:0]  sqrt_root;

	logic [UW-1:0]        ua_m, ub_m;
	logic [UW-1:0]        gain_mag, spare_mag;
	logic [49:0]          s_sum;
	logic [32:0]          sq_t;
	logic [31:0]          m_next;
	logic [LOG_ITERS-1:0] f_next;
	logic [5:0]           ex;
	logic [33:0]          nlog_next;
	logic [63:0]          l_sum;
	logic [33:0]          l_full;
	logic signed [51:0]   pval, bias_ext, acc;
	logic                 out_go;

	assign ua_m      = item.uniform_a & UMASK;
	assign ub_m      = item.uniform_b & UMASK;
	assign gain_mag  = gain_q[UW-1] ? UW'(-gain_q) : UW'(gain_q);
	assign spare_mag = spare_q[UW-1] ? UW'(-spare_q) : UW'(spare_q);
	assign s_sum     = 50'(sq1_q) + 50'(mul_prod[48:0]);

	// one log2 step: square the Q1.31 mantissa, renormalise, emit a fraction bit
	assign sq_t      = mul_prod[63:31];
	assign m_next    = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
	assign f_next    = {f_q[LOG_ITERS-2:0], sq_t[32]};
	assign ex        = cnt_q + 6'd1;
	assign nlog_next = {ex, 28'b0} - 34'(f_next);
	assign l_sum     = mul_prod[63:0] + 64'(1 << 29);
	assign l_full    = l_sum[63:30];

	assign pval     = pneg_q ? -$signed({4'b0, mul_prod[47:0]})
	                         : $signed({4'b0, mul_prod[47:0]});
	assign bias_ext = 52'(bias_q);
	assign acc      = pval + (noise_kind_q ? (bias_ext <<< 20) : (bias_ext <<< 24));
	assign out_go   = !out_valid_q || result.ready;
	assign sqrt_x   = mul_prod[63:18];

	gnp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	gnp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(s_q),
		.done(div_done), .quo(div_quo)
	);

	gnp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .x(sqrt_x),
		.done(sqrt_done), .root(sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		div_num    = sq1_q;
		sqrt_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid)
					state_d = S_LOAD;
			end
			S_LOAD: begin
				mul_start = 1'b1;
				if (!noise_kind_q || spare_valid_q) begin
					mul_a   = noise_kind_q ? MUL_AW'(spare_mag) : MUL_AW'(ua_q);
					mul_b   = MUL_BW'(gain_mag);
					state_d = S_SCALE;
				end else begin
					mul_a   = MUL_AW'(mag1_q);
					mul_b   = MUL_BW'(mag1_q);
					state_d = S_SQ1;
				end
			end
			S_SQ1: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(mag2_q);
					mul_b     = MUL_BW'(mag2_q);
					state_d   = S_SQ2;
				end
			end
			S_SQ2: begin
				if (mul_done) begin
					if (s_sum == '0 || s_sum[49:48] != 2'b00)
						state_d = S_DONE;
					else
						state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (norm_q[47]) begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(norm_q[47:16]);
					mul_b     = MUL_BW'(norm_q[47:16]);
					state_d   = S_LOG;
				end
			end
			S_LOG: begin
				if (mul_done) begin
					mul_start = 1'b1;
					if (it_q == 5'(LOG_ITERS - 1)) begin
						mul_a   = MUL_AW'(nlog_next);
						mul_b   = MUL_BW'(LN2_Q29);
						state_d = S_LN;
					end else begin
						mul_a = MUL_AW'(m_next);
						mul_b = MUL_BW'(m_next);
					end
				end
			end
			S_LN: begin
				if (mul_done) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					mul_start = 1'b1;
					mul_a     = MUL_AW'(div_quo);
					mul_b     = MUL_BW'(l_q);
					state_d   = S_RL;
				end
			end
			S_RL: begin
				if (mul_done) begin
					sqrt_start = 1'b1;
					state_d    = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sqrt_done) begin
					if (!sel_q) begin
						div_start = 1'b1;
						div_num   = sq2_q;
						state_d   = S_DIV;
					end else begin
						mul_start = 1'b1;
						mul_a     = MUL_AW'(n1_q);
						mul_b     = MUL_BW'(gain_mag);
						state_d   = S_SCALE;
					end
				end
			end
			S_SCALE: begin
				if (mul_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (out_go)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_kind_q  <= 1'b1;
			spare_q       <= '0;
			spare_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg.valid)
				noise_kind_q <= cfg.noise_kind;
			if (state_q == S_LOAD && noise_kind_q && spare_valid_q)
				spare_valid_q <= 1'b0;
			if (state_q == S_SQRT && sqrt_done && sel_q) begin
				spare_valid_q <= 1'b1;
				spare_q       <= neg2_q ? -$signed({1'b0, sqrt_root})
				                        : $signed({1'b0, sqrt_root});
			end
			if (state_q == S_DONE && out_go)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			ua_q   <= ua_m;
			gain_q <= item.gain;
			bias_q <= item.bias;
			mag1_q <= umag(ua_m);
			mag2_q <= umag(ub_m);
			neg1_q <= ~ua_m[UW-1];
			neg2_q <= ~ub_m[UW-1];
		end
		if (state_q == S_LOAD) begin
			pneg_q <= noise_kind_q ? (spare_q[UW-1] ^ gain_q[UW-1]) : gain_q[UW-1];
			sel_q  <= 1'b0;
		end
		if (state_q == S_SQ1 && mul_done)
			sq1_q <= mul_prod[48:0];
		if (state_q == S_SQ2 && mul_done) begin
			sq2_q        <= mul_prod[48:0];
			s_q          <= s_sum[47:0];
			norm_q       <= s_sum[47:0];
			cnt_q        <= '0;
			res_sample_q <= '0;
			res_rej_q    <= 1'b1;
		end
		if (state_q == S_NORM) begin
			if (!norm_q[47]) begin
				norm_q <= norm_q << 1;
				cnt_q  <= cnt_q + 6'd1;
			end else begin
				it_q <= '0;
				f_q  <= '0;
			end
		end
		if (state_q == S_LOG && mul_done) begin
			f_q  <= f_next;
			it_q <= it_q + 5'd1;
		end
		if (state_q == S_LN && mul_done)
			l_q <= (l_full[33:32] != 2'b00) ? 32'hffffffff : l_full[31:0];
		if (state_q == S_SQRT && sqrt_done) begin
			if (!sel_q) begin
				n1_q  <= sqrt_root;
				sel_q <= 1'b1;
			end else begin
				pneg_q <= neg1_q ^ gain_q[UW-1];
			end
		end
		if (state_q == S_SCALE && mul_done) begin
			res_sample_q <= round_sat(acc, !noise_kind_q);
			res_rej_q    <= 1'b0;
		end
		if (state_q == S_DONE && out_go) begin
			out_sample_q <= res_sample_q;
			out_rej_q    <= res_rej_q;
		end
	end

	assign item.ready      = (state_q == S_IDLE);
	assign cfg.ready       = 1'b1;
	assign result.valid    = out_valid_q;
	assign result.sample   = out_sample_q;
	assign result.rejected = out_rej_q;
endmodule
`default_nettype wire

FILE: hw/rtl/gnp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gnp_checker import gnp_pkg::*; (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          item_valid,
	input wire logic          item_ready,
	input wire logic          res_valid,
	input wire logic          res_ready,
	input wire logic [SW-1:0] sample,
	input wire logic          rejected
);
	// one item at a time: no back-to-back transactions on the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input accepted while an item is in work");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && rejected |-> sample == '0)
		else $error("rejected result with non-zero sample");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(sample) && $stable(rejected))
		else $error("stalled result changed");
endmodule

bind gaussian_noise_polar_core gnp_checker u_gnp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.sample(result.sample),
	.rejected(result.rejected)
);
`default_nettype wire
